// ===== src/cbsm_pkg.sv =====
// Package for the cartridge bank switch mapper: address map constants,
// register indexes, target codes and the result type.
// No dependencies.
package cbsm_pkg;

  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned ROM_ADDR_W   = 27;
  localparam int unsigned PADDR_W      = 5;
  localparam int unsigned PDATA_W      = 32;
  localparam int unsigned S_TDATA_W    = 32;
  localparam int unsigned M_TDATA_W    = 40;
  localparam int unsigned M_TUSER_W    = 4;

  localparam int unsigned RAM_BYTES_DEF  = 65536;
  localparam int unsigned SRAM_BYTES_DEF = 65536;
  localparam int unsigned BANK_WINDOWS   = 7;
  localparam int unsigned PAGE_BYTES     = 524288;
  localparam int unsigned PAGE_BITS      = $clog2(PAGE_BYTES);
  localparam int unsigned WIN_W          = $clog2(BANK_WINDOWS + 1);

  localparam logic [ADDR_W-1:0] FIXED_LAST      = 24'h07FFFF;
  localparam logic [ADDR_W-1:0] BANKED_LAST     = 24'h3FFFFF;
  localparam logic [ADDR_W-1:0] CTRL_ENABLE     = 24'hA130F1;
  localparam logic [ADDR_W-1:0] CTRL_PAGE_FIRST = 24'hA130F3;
  localparam logic [ADDR_W-1:0] CTRL_PAGE_LAST  = 24'hA131FF;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic MODE_READ  = 1'b0;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_SRAM = 3'd3,
    TGT_CTRL = 3'd4
  } target_e;

  typedef enum logic [2:0] {
    REG_ROM_FIRST    = 3'd0,
    REG_ROM_LAST     = 3'd1,
    REG_RAM_FIRST    = 3'd2,
    REG_RAM_LAST     = 3'd3,
    REG_SRAM_FIRST   = 3'd4,
    REG_SRAM_LAST    = 3'd5,
    REG_SRAM_PRESENT = 3'd6,
    REG_BANKED_ROM   = 3'd7
  } reg_e;

  typedef struct packed {
    logic                  status;
    target_e               target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  rd_ram;
    logic                  rd_sram;
  } result_t;

endpackage

// ===== src/cbsm_store.sv =====
// Single-port byte store with registered read data, one access per cycle.
// No dependencies.
module cbsm_store #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [7:0]               wdata_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cartridge_bank_switch_mapper_core.sv =====
// Cartridge bank switch mapper: bus access decode, ROM page translation,
// RAM and SRAM byte stores. Uses cbsm_pkg and cbsm_store.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tdata {write_data, address}, tuser mode
// m_axis   out  tvalid/tready          tdata {read_data, rom_address}, tuser {target, status}
// apb      in   psel/penable/pready    eight config registers at 4*i
//
// One item per cycle while the output is ready, through stage one and stage two.
// Stage one decodes and issues the single store access; stage two holds the
// result while the store's registered read data completes it.
// Store reads and writes happen in item order on leaving stage one: no forwarding.
// Reset clears config, page registers and pipeline valids; stores are not cleared.
// A stalled output holds stage two; stage one keeps accepting until it fills.
module cartridge_bank_switch_mapper_core #(
  parameter int unsigned RAM_BYTES  = cbsm_pkg::RAM_BYTES_DEF,
  parameter int unsigned SRAM_BYTES = cbsm_pkg::SRAM_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // address [23:0], write_data [31:24]
  input  logic [cbsm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // mode [0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rom_address [26:0], read_data [34:27], zero [39:35]
  output logic [cbsm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status [0], target [3:1]
  output logic [cbsm_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbsm_pkg::PADDR_W-1:0]    paddr,
  input  logic [cbsm_pkg::PDATA_W-1:0]    pwdata,
  output logic [cbsm_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  import cbsm_pkg::*;

  localparam int unsigned RAM_AW  = $clog2(RAM_BYTES);
  localparam int unsigned SRAM_AW = $clog2(SRAM_BYTES);

  logic [ADDR_W-1:0] rom_first_q, rom_last_q, ram_first_q, ram_last_q;
  logic [ADDR_W-1:0] sram_first_q, sram_last_q;
  logic              sram_present_q, banked_rom_q;
  logic              banking_on_q, banking_on_d;
  logic [7:0]        page_q [BANK_WINDOWS];

  logic              s1_v_q, s1_mode_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [DATA_W-1:0] s1_wdata_q;
  logic              s2_v_q;
  result_t           s2_res_q, s2_res_d;

  logic              s1_ready, s2_ready, adv1;
  logic              cfg_wr;

  logic [ADDR_W-1:0] ram_off, sram_off;
  logic              ram_hit_r, sram_hit_r, ram_hit_w, sram_hit_w;
  logic              ram_fit, sram_fit, rom_hit;
  logic              ram_en, ram_we, sram_en, sram_we;
  logic              page_wr;
  logic [WIN_W-1:0]  win, page_idx;
  logic [7:0]        pg;
  logic [7:0]        ram_rdata, sram_rdata, rd_byte;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_first_q    <= '0;
      rom_last_q     <= '0;
      ram_first_q    <= '0;
      ram_last_q     <= '0;
      sram_first_q   <= '0;
      sram_last_q    <= '0;
      sram_present_q <= 1'b0;
      banked_rom_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[4:2]))
        REG_ROM_FIRST:    rom_first_q    <= pwdata[ADDR_W-1:0];
        REG_ROM_LAST:     rom_last_q     <= pwdata[ADDR_W-1:0];
        REG_RAM_FIRST:    ram_first_q    <= pwdata[ADDR_W-1:0];
        REG_RAM_LAST:     ram_last_q     <= pwdata[ADDR_W-1:0];
        REG_SRAM_FIRST:   sram_first_q   <= pwdata[ADDR_W-1:0];
        REG_SRAM_LAST:    sram_last_q    <= pwdata[ADDR_W-1:0];
        REG_SRAM_PRESENT: sram_present_q <= pwdata[0];
        REG_BANKED_ROM:   banked_rom_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_e'(paddr[4:2]))
      REG_ROM_FIRST:    prdata = PDATA_W'(rom_first_q);
      REG_ROM_LAST:     prdata = PDATA_W'(rom_last_q);
      REG_RAM_FIRST:    prdata = PDATA_W'(ram_first_q);
      REG_RAM_LAST:     prdata = PDATA_W'(ram_last_q);
      REG_SRAM_FIRST:   prdata = PDATA_W'(sram_first_q);
      REG_SRAM_LAST:    prdata = PDATA_W'(sram_last_q);
      REG_SRAM_PRESENT: prdata = PDATA_W'(sram_present_q);
      REG_BANKED_ROM:   prdata = PDATA_W'(banked_rom_q);
      default:          prdata = '0;
    endcase
  end

  // Pipeline handshake
  assign s2_ready      = ~s2_v_q | m_axis_tready;
  assign s1_ready      = ~s1_v_q | s2_ready;
  assign adv1          = s1_v_q & s2_ready;
  assign s_axis_tready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s1_ready) begin
      s1_mode_q  <= s_axis_tuser;
      s1_addr_q  <= s_axis_tdata[ADDR_W-1:0];
      s1_wdata_q <= s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
    if (adv1) begin
      s2_res_q <= s2_res_d;
    end
  end

  // Window decode on stage one
  assign ram_off    = s1_addr_q - ram_first_q;
  assign sram_off   = s1_addr_q - sram_first_q;
  assign ram_fit    = ram_off < ADDR_W'(RAM_BYTES);
  assign sram_fit   = sram_off < ADDR_W'(SRAM_BYTES);
  assign rom_hit    = (s1_addr_q >= rom_first_q) && (s1_addr_q <= rom_last_q);
  assign ram_hit_r  = (s1_addr_q >= ram_first_q) && (s1_addr_q <= ram_last_q);
  assign sram_hit_r = sram_present_q && (s1_addr_q >= sram_first_q) &&
                      (s1_addr_q <= sram_last_q);
  assign ram_hit_w  = (s1_addr_q >= ram_first_q) &&
                      (({1'b0, s1_addr_q} + 25'd2) <= {1'b0, ram_last_q});
  assign sram_hit_w = sram_present_q && (s1_addr_q >= sram_first_q) &&
                      (({1'b0, s1_addr_q} + 25'd2) <= {1'b0, sram_last_q});

  assign win      = s1_addr_q[PAGE_BITS+WIN_W-1:PAGE_BITS];
  assign pg       = page_q[win - WIN_W'(1)];
  assign page_idx = s1_addr_q[3:1] - WIN_W'(1);

  always_comb begin
    s2_res_d     = '{status: STATUS_OK, target: TGT_NONE, rom_address: '0,
                     rd_ram: 1'b0, rd_sram: 1'b0};
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    sram_en      = 1'b0;
    sram_we      = 1'b0;
    page_wr      = 1'b0;
    banking_on_d = banking_on_q;
    if (s1_mode_q == MODE_READ) begin
      if (rom_hit && !(banked_rom_q && banking_on_q)) begin
        s2_res_d.target      = TGT_ROM;
        s2_res_d.rom_address = ROM_ADDR_W'(s1_addr_q - rom_first_q);
      end else if (banked_rom_q && s1_addr_q <= FIXED_LAST) begin
        s2_res_d.target      = TGT_ROM;
        s2_res_d.rom_address = ROM_ADDR_W'(s1_addr_q);
      end else if (banked_rom_q && s1_addr_q <= BANKED_LAST) begin
        s2_res_d.target = TGT_ROM;
        if (pg != 8'd0) begin
          s2_res_d.rom_address = {pg, s1_addr_q[PAGE_BITS-1:0]};
        end else begin
          s2_res_d.rom_address = ROM_ADDR_W'(s1_addr_q);
        end
      end else if (ram_hit_r) begin
        if (ram_fit) begin
          s2_res_d.target = TGT_RAM;
          s2_res_d.rd_ram = 1'b1;
          ram_en          = 1'b1;
        end else begin
          s2_res_d.status = STATUS_ERR;
        end
      end else if (sram_hit_r) begin
        if (sram_fit) begin
          s2_res_d.target  = TGT_SRAM;
          s2_res_d.rd_sram = 1'b1;
          sram_en          = 1'b1;
        end else begin
          s2_res_d.status = STATUS_ERR;
        end
      end else begin
        s2_res_d.status = STATUS_ERR;
      end
    end else begin
      if (ram_hit_w) begin
        if (ram_fit) begin
          s2_res_d.target = TGT_RAM;
          ram_en          = 1'b1;
          ram_we          = 1'b1;
        end
      end else if (sram_hit_w) begin
        if (sram_fit) begin
          s2_res_d.target = TGT_SRAM;
          sram_en         = 1'b1;
          sram_we         = 1'b1;
        end
      end else if (s1_addr_q == CTRL_ENABLE) begin
        s2_res_d.target = TGT_CTRL;
        banking_on_d    = 1'b1;
      end else if (banked_rom_q && s1_addr_q >= CTRL_PAGE_FIRST &&
                   s1_addr_q <= CTRL_PAGE_LAST) begin
        s2_res_d.target = TGT_CTRL;
        banking_on_d    = 1'b1;
        page_wr         = s1_addr_q[3:1] != 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banking_on_q <= 1'b0;
      for (int i = 0; i < BANK_WINDOWS; i++) begin
        page_q[i] <= '0;
      end
    end else if (adv1) begin
      banking_on_q <= banking_on_d;
      if (page_wr) begin
        page_q[page_idx] <= s1_wdata_q;
      end
    end
  end

  cbsm_store #(
    .DEPTH(RAM_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (adv1 & ram_en),
    .we_i   (ram_we),
    .addr_i (ram_off[RAM_AW-1:0]),
    .wdata_i(s1_wdata_q),
    .rdata_o(ram_rdata)
  );

  cbsm_store #(
    .DEPTH(SRAM_BYTES)
  ) u_sram (
    .clk_i  (clk_i),
    .en_i   (adv1 & sram_en),
    .we_i   (sram_we),
    .addr_i (sram_off[SRAM_AW-1:0]),
    .wdata_i(s1_wdata_q),
    .rdata_o(sram_rdata)
  );

  // Result
  assign rd_byte = s2_res_q.rd_ram  ? ram_rdata  :
                   s2_res_q.rd_sram ? sram_rdata : 8'd0;

  assign m_axis_tvalid = s2_v_q;
  assign m_axis_tdata  = {5'd0, rd_byte, s2_res_q.rom_address};
  assign m_axis_tuser  = {s2_res_q.target, s2_res_q.status};

  a_err_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && s2_res_q.status == STATUS_ERR |-> s2_res_q.target == TGT_NONE)
    else $error("bus error carries a target");

  a_rom_addr_only_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && s2_res_q.rom_address != '0 |-> s2_res_q.target == TGT_ROM)
    else $error("rom address outside a ROM hit");

  a_read_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (s2_res_q.rd_ram || s2_res_q.rd_sram) |->
      (s2_res_q.target == TGT_RAM || s2_res_q.target == TGT_SRAM) &&
      !(s2_res_q.rd_ram && s2_res_q.rd_sram))
    else $error("store read select inconsistent");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && s1_v_q)
    else $error("input stalled without output backpressure");

  a_banking_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    banking_on_q |=> banking_on_q)
    else $error("banking enable dropped");

endmodule

// ===== verif/tb.sv =====
// Testbench for cartridge_bank_switch_mapper_core: drives bus accesses on the
// input stream and register writes on APB, predicts each reply in a scoreboard
// class and checks the output stream item by item. Depends on cbsm_pkg.
module tb;
  import cbsm_pkg::*;

  localparam int unsigned RAM_DEPTH  = RAM_BYTES_DEF;
  localparam int unsigned SRAM_DEPTH = SRAM_BYTES_DEF;
  localparam logic        MODE_WRITE = ~MODE_READ;
  localparam logic [23:0] ADDR_MAX   = 24'hFFFFFF;

  typedef enum int {
    SET_ZERO,
    SET_FLAT,
    SET_BANKED,
    SET_WIDE,
    SET_TOP,
    SET_RANDOM
  } setting_e;

  typedef struct {
    logic                  status;
    target_e               target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [DATA_W-1:0]     read_data;
  } reply_t;

  class bus_map_scoreboard;
    bit [23:0] rom_first, rom_last, ram_first, ram_last, sram_first, sram_last;
    bit        sram_present, banked_rom;
    bit        banking_on;
    bit [7:0]  page_sel [BANK_WINDOWS];
    bit [7:0]  ram_mem [RAM_DEPTH];
    bit        ram_known [RAM_DEPTH];
    bit [7:0]  sram_mem [SRAM_DEPTH];
    bit        sram_known [SRAM_DEPTH];
    reply_t    pending_replies [$];
    int        mismatches;
    int        checked;

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void set_reg(reg_e idx, logic [31:0] v);
      case (idx)
        REG_ROM_FIRST:    rom_first = v[23:0];
        REG_ROM_LAST:     rom_last = v[23:0];
        REG_RAM_FIRST:    ram_first = v[23:0];
        REG_RAM_LAST:     ram_last = v[23:0];
        REG_SRAM_FIRST:   sram_first = v[23:0];
        REG_SRAM_LAST:    sram_last = v[23:0];
        REG_SRAM_PRESENT: sram_present = v[0];
        REG_BANKED_ROM:   banked_rom = v[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(reg_e idx);
      case (idx)
        REG_ROM_FIRST:    return {8'h00, rom_first};
        REG_ROM_LAST:     return {8'h00, rom_last};
        REG_RAM_FIRST:    return {8'h00, ram_first};
        REG_RAM_LAST:     return {8'h00, ram_last};
        REG_SRAM_FIRST:   return {8'h00, sram_first};
        REG_SRAM_LAST:    return {8'h00, sram_last};
        REG_SRAM_PRESENT: return {31'b0, sram_present};
        default:          return {31'b0, banked_rom};
      endcase
    endfunction

    function reply_t decode_access(logic mode, logic [23:0] a, logic [7:0] wd, bit commit,
                                   output bit unwritten);
      reply_t      r;
      int unsigned au, off, pg;
      logic [2:0]  half;
      au = a;
      unwritten = 1'b0;
      r.status = STATUS_OK;
      r.target = TGT_NONE;
      r.rom_address = '0;
      r.read_data = '0;
      if (mode == MODE_READ) begin
        if (au >= rom_first && au <= rom_last && !(banked_rom && banking_on)) begin
          r.target = TGT_ROM;
          r.rom_address = ROM_ADDR_W'(au - rom_first);
        end else if (banked_rom && au <= FIXED_LAST) begin
          r.target = TGT_ROM;
          r.rom_address = ROM_ADDR_W'(au);
        end else if (banked_rom && au <= BANKED_LAST) begin
          off = au % PAGE_BYTES;
          pg = page_sel[au / PAGE_BYTES - 1];
          r.target = TGT_ROM;
          r.rom_address = ROM_ADDR_W'((pg != 0) ? pg * PAGE_BYTES + off : au);
        end else if (au >= ram_first && au <= ram_last) begin
          off = au - ram_first;
          if (off < RAM_DEPTH) begin
            r.target = TGT_RAM;
            r.read_data = ram_mem[off];
            unwritten = !ram_known[off];
          end else begin
            r.status = STATUS_ERR;
          end
        end else if (sram_present && au >= sram_first && au <= sram_last) begin
          off = au - sram_first;
          if (off < SRAM_DEPTH) begin
            r.target = TGT_SRAM;
            r.read_data = sram_mem[off];
            unwritten = !sram_known[off];
          end else begin
            r.status = STATUS_ERR;
          end
        end else begin
          r.status = STATUS_ERR;
        end
      end else begin
        if (au >= ram_first && au + 2 <= ram_last) begin
          off = au - ram_first;
          if (off < RAM_DEPTH) begin
            r.target = TGT_RAM;
            if (commit) begin
              ram_mem[off] = wd;
              ram_known[off] = 1'b1;
            end
          end
        end else if (sram_present && au >= sram_first && au + 2 <= sram_last) begin
          off = au - sram_first;
          if (off < SRAM_DEPTH) begin
            r.target = TGT_SRAM;
            if (commit) begin
              sram_mem[off] = wd;
              sram_known[off] = 1'b1;
            end
          end
        end else if (a == CTRL_ENABLE) begin
          r.target = TGT_CTRL;
          if (commit) banking_on = 1'b1;
        end else if (a >= CTRL_PAGE_FIRST && a <= CTRL_PAGE_LAST && banked_rom) begin
          r.target = TGT_CTRL;
          half = a[3:1];
          if (commit) begin
            banking_on = 1'b1;
            // low nibble 0 or 1 selects no page
            if (half != 0) page_sel[half - 1] = wd;
          end
        end
      end
      return r;
    endfunction

    function bit reads_unwritten(logic [23:0] a);
      reply_t r;
      bit     u;
      r = decode_access(MODE_READ, a, 8'h00, 1'b0, u);
      return u;
    endfunction

    function void note_access(logic mode, logic [23:0] a, logic [7:0] wd);
      bit u;
      pending_replies.push_back(decode_access(mode, a, wd, 1'b1, u));
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void check_reply(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      reply_t want;
      checked++;
      if (pending_replies.size() == 0) begin
        flag($sformatf("reply with no access pending: tdata %h tuser %h", tdata, tuser));
        return;
      end
      want = pending_replies.pop_front();
      if (tuser[0] !== want.status || tuser[3:1] !== want.target ||
          tdata[26:0] !== want.rom_address || tdata[34:27] !== want.read_data ||
          tdata[39:35] !== 5'b0) begin
        flag($sformatf({"reply %0d: expected status %0d target %0d rom %h data %h, ",
                        "got status %b target %b rom %h data %h pad %b"},
                       checked, want.status, want.target, want.rom_address, want.read_data,
                       tuser[0], tuser[3:1], tdata[26:0], tdata[34:27], tdata[39:35]));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = MODE_READ;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  bus_map_scoreboard board = new();
  int  src_idle_pct = 26;
  int  sink_idle_pct = 56;
  int  items_sent = 0;
  int  settings_used = 0;
  logic hold_off = 1'b0;

  cartridge_bank_switch_mapper_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_reply(m_axis_tdata, m_axis_tuser);
  end

  // long output stall while the sender keeps offering items
  initial begin
    wait (items_sent >= 400);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #(12 * 300000);
    $display("Timeout: run did not finish, %0d replies still pending", board.pending());
    $display("Some tests failed");
    $finish;
  end

  task automatic apb_write(reg_e idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(reg_e idx, output logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    v = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] v);
    logic [31:0] got;
    apb_write(idx, v);
    board.set_reg(idx, v);
    apb_read(idx, got);
    if (got !== board.reg_value(idx))
      board.flag($sformatf("register %s reads %h, expected %h", idx.name(), got,
                           board.reg_value(idx)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // junk in the upper pwdata bits must be dropped by the register
  task automatic load_setting(logic [23:0] rf, logic [23:0] rl, logic [23:0] mf,
                              logic [23:0] ml, logic [23:0] sf, logic [23:0] sl,
                              logic sp, logic br);
    wait_drained();
    write_reg(REG_ROM_FIRST, ($urandom & 32'hFF00_0000) | rf);
    write_reg(REG_ROM_LAST, ($urandom & 32'hFF00_0000) | rl);
    write_reg(REG_RAM_FIRST, ($urandom & 32'hFF00_0000) | mf);
    write_reg(REG_RAM_LAST, ($urandom & 32'hFF00_0000) | ml);
    write_reg(REG_SRAM_FIRST, ($urandom & 32'hFF00_0000) | sf);
    write_reg(REG_SRAM_LAST, ($urandom & 32'hFF00_0000) | sl);
    write_reg(REG_SRAM_PRESENT, ($urandom & 32'hFFFF_FFFE) | sp);
    write_reg(REG_BANKED_ROM, ($urandom & 32'hFFFF_FFFE) | br);
    settings_used++;
  endtask

  task automatic rand_window(output logic [23:0] f, output logic [23:0] l);
    int unsigned span;
    f = 24'($urandom);
    case ($urandom_range(0, 3))
      0:       span = $urandom_range(0, 300);
      1:       span = $urandom_range(0, 2 * RAM_DEPTH);
      2:       span = $urandom_range(0, ADDR_MAX);
      default: span = 0;
    endcase
    l = (f + span > ADDR_MAX) ? ADDR_MAX : 24'(f + span);
    if ($urandom_range(0, 7) == 0) l = 24'($urandom);
  endtask

  task automatic apply_setting(setting_e s);
    logic [23:0] rf, rl, mf, ml, sf, sl;
    case (s)
      SET_ZERO:   load_setting(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
      SET_FLAT:   load_setting(24'h000000, 24'h1FFFFF, 24'hFF0000, 24'hFFFFFF,
                               24'h200000, 24'h20FFFF, 1'b1, 1'b0);
      SET_BANKED: load_setting(24'h100000, 24'h3FFFFF, 24'hE00000, 24'hE0FFFF,
                               24'h600000, 24'h61FFFF, 1'b1, 1'b1);
      // empty ROM window, RAM deeper than its store, SRAM too short for writes
      SET_WIDE:   load_setting(24'hFFFFFF, 24'h000000, 24'h800000, 24'hFFFFFF,
                               24'h000000, 24'h000001, 1'b1, 1'b0);
      SET_TOP:    load_setting(ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX,
                               ADDR_MAX, ADDR_MAX, 1'b1, 1'b1);
      default: begin
        rand_window(rf, rl);
        rand_window(mf, ml);
        rand_window(sf, sl);
        load_setting(rf, rl, mf, ml, sf, sl, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  task automatic send_item(logic mode, logic [23:0] addr, logic [7:0] wd);
    // never read a store byte that was not written: turn such a read into a write
    if (mode == MODE_READ && board.reads_unwritten(addr)) mode = MODE_WRITE;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {wd, addr};
    s_axis_tuser <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_access(mode, addr, wd);
    items_sent++;
  endtask

  task automatic random_access(output logic mode, output logic [23:0] addr,
                               output logic [7:0] wd);
    int unsigned pick, off;
    logic [23:0] mark;
    pick = $urandom_range(0, 99);
    wd = 8'($urandom_range(0, 255));
    off = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 63)
                                      : $urandom_range(0, RAM_DEPTH + 255);
    mode = MODE_READ;
    if (pick < 20) begin
      mode = MODE_WRITE;
      addr = 24'(board.ram_first + off);
    end else if (pick < 40) begin
      addr = 24'(board.ram_first + off);
    end else if (pick < 50) begin
      mode = MODE_WRITE;
      addr = 24'(board.sram_first + off);
    end else if (pick < 60) begin
      addr = 24'(board.sram_first + off);
    end else if (pick < 72) begin
      addr = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, BANKED_LAST))
                                         : 24'(board.rom_first + $urandom_range(0, 4095));
    end else if (pick < 80) begin
      mode = MODE_WRITE;
      case ($urandom_range(0, 3))
        0:       addr = CTRL_ENABLE;
        1, 2:    addr = 24'(CTRL_PAGE_FIRST - 3 + $urandom_range(0, 31));
        default: addr = 24'($urandom_range(CTRL_PAGE_FIRST - 2, CTRL_PAGE_LAST + 2));
      endcase
    end else if (pick < 90) begin
      case ($urandom_range(0, 11))
        0:       mark = board.rom_first;
        1:       mark = board.rom_last;
        2:       mark = board.ram_first;
        3:       mark = board.ram_last;
        4:       mark = board.sram_first;
        5:       mark = board.sram_last;
        6:       mark = FIXED_LAST;
        7:       mark = BANKED_LAST;
        8:       mark = CTRL_ENABLE;
        9:       mark = CTRL_PAGE_LAST;
        10:      mark = 24'(board.ram_first + RAM_DEPTH);
        default: mark = 24'(board.sram_first + SRAM_DEPTH);
      endcase
      addr = 24'(mark + $urandom_range(0, 4) - 2);
      mode = 1'($urandom_range(0, 1));
    end else begin
      addr = 24'($urandom);
      mode = 1'($urandom_range(0, 1));
    end
  endtask

  initial begin : stimulus
    logic        mode;
    logic [23:0] addr;
    logic [7:0]  wd;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: one-byte ROM window at zero, RAM too short for writes
    send_item(MODE_READ, 24'h000000, 8'h00);
    send_item(MODE_READ, 24'h000001, 8'h00);
    send_item(MODE_WRITE, 24'h000000, 8'hFF);

    apply_setting(SET_BANKED);
    send_item(MODE_READ, 24'h100000, 8'h00);
    send_item(MODE_READ, 24'h3FFFFF, 8'h00);
    send_item(MODE_READ, 24'h000000, 8'h00);
    send_item(MODE_WRITE, 24'hA130F3, 8'hFF);
    send_item(MODE_WRITE, 24'hA130FF, 8'h01);
    send_item(MODE_WRITE, 24'hA13100, 8'h55);
    send_item(MODE_WRITE, 24'hA131F1, 8'hAA);
    send_item(MODE_READ, 24'h080000, 8'h00);
    send_item(MODE_READ, 24'h3FFFFF, 8'h00);
    send_item(MODE_READ, 24'h100000, 8'h00);
    send_item(MODE_READ, 24'h07FFFF, 8'h00);
    send_item(MODE_WRITE, CTRL_ENABLE, 8'h00);
    send_item(MODE_WRITE, 24'hE00000, 8'h00);
    send_item(MODE_WRITE, 24'hE0FFFD, 8'hFF);
    send_item(MODE_WRITE, 24'hE0FFFE, 8'h12);
    send_item(MODE_READ, 24'hE00000, 8'h00);
    send_item(MODE_READ, 24'hE0FFFD, 8'h00);
    send_item(MODE_WRITE, 24'h600000, 8'h5A);
    send_item(MODE_READ, 24'h600000, 8'h00);
    send_item(MODE_WRITE, 24'h610000, 8'h33);
    send_item(MODE_READ, 24'h610000, 8'h00);
    send_item(MODE_READ, ADDR_MAX, 8'h00);
    send_item(MODE_WRITE, 24'h800000, 8'h77);
    send_item(MODE_WRITE, 24'hA130F2, 8'h0F);

    for (int batch = 0; batch < 12; batch++) begin
      if (batch == 4) begin
        src_idle_pct = 56;
        sink_idle_pct = 26;
      end else if (batch == 8) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case (batch % 6)
        0:       apply_setting(SET_FLAT);
        1:       apply_setting(SET_BANKED);
        3:       apply_setting(SET_WIDE);
        5:       apply_setting((batch < 6) ? SET_ZERO : SET_TOP);
        default: apply_setting(SET_RANDOM);
      endcase
      for (int n = 0; n < 125; n++) begin
        random_access(mode, addr, wd);
        send_item(mode, addr, wd);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d bus accesses under %0d mapper settings, with one long output stall;",
             items_sent, settings_used);
    $display("%0d replies checked, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cbsm_pkg.sv
src/cbsm_store.sv
src/cartridge_bank_switch_mapper_core.sv
verif/tb.sv
